// ===== rtl/greedy_word_wrap_breaker_unit_defines.svh =====
// Assertion macros for the checker file of the word-wrap breaker.
// No dependencies; included by bare file name.
`ifndef GREEDY_WORD_WRAP_BREAKER_UNIT_DEFINES_SVH
`define GREEDY_WORD_WRAP_BREAKER_UNIT_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define GWWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define GWWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gwwb_pkg.sv =====
// Types, constants and helpers for the greedy word-wrap breaker.
// No dependencies; imported by the core, the result queue and the top level.
package gwwb_pkg;

  // Special text bytes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;

  // Register map: word index of max_width
  localparam logic REG_MAX_WIDTH = 1'b0;
  localparam logic [15:0] MAX_WIDTH_RESET = 16'd600;

  // Saturation limit of the pixel widths
  localparam logic [19:0] WIDTH_MAX = 20'hFFFFF;

  // Table and text limits
  localparam longint MAX_BREAKS = 256;
  localparam longint MAX_TEXT   = 65536;
  localparam longint SLOT_CAP_L  = (MAX_BREAKS - 1 > 255) ? 255 : MAX_BREAKS - 1;
  localparam longint INDEX_CAP_L = (MAX_TEXT - 1 > 65535) ? 65535 : MAX_TEXT - 1;
  localparam logic [7:0]  SLOT_CAP  = SLOT_CAP_L[7:0];
  localparam logic [15:0] INDEX_CAP = INDEX_CAP_L[15:0];
  localparam logic [7:0]  SLOT_FULL = 8'hFF;

  // One line break word
  typedef struct packed {
    logic signed [16:0] pos;
    logic [7:0]         slot;
    logic               ovf;
    logic               last;
  } brk_t;

  // Breaks produced by one text byte
  typedef struct packed {
    brk_t [1:0] res;
    logic [1:0] count;
  } brk_pair_t;

  function automatic logic [19:0] sat_add(input logic [19:0] a, input logic [7:0] b);
    logic [20:0] s;
    s = {1'b0, a} + {13'b0, b};
    return s[20] ? WIDTH_MAX : s[19:0];
  endfunction

endpackage

// ===== rtl/gwwb_core.sv =====
// Running wrap state and break generation for one text byte per cycle while accept is high.
// Depends on gwwb_pkg.
module gwwb_core
  import gwwb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        new_text,
  input  logic [7:0]  character,
  input  logic [7:0]  glyph_width,
  input  logic [15:0] max_width,
  output brk_pair_t   brk
);

  logic [15:0] char_index, char_index_next;
  logic [19:0] running_width, running_width_next;
  logic [16:0] word_start, word_start_next;
  logic [19:0] word_width, word_width_next;
  logic [7:0]  break_count, break_count_next;

  // State as seen by this byte (a new text starts from zero)
  logic [15:0] ci_b;
  logic [19:0] rw_b, ww_b;
  logic [16:0] ws_b;
  logic [7:0]  bc_b;
  logic        is_sp, is_nl, is_cr, over;
  logic [16:0] ci_ext, next_start;
  logic        ok0, ok1;
  logic [7:0]  bc_one, bc_two;

  assign ci_b = new_text ? '0 : char_index;
  assign rw_b = new_text ? '0 : running_width;
  assign ws_b = new_text ? '0 : word_start;
  assign ww_b = new_text ? '0 : word_width;
  assign bc_b = new_text ? '0 : break_count;

  assign is_sp = (character == CH_SPACE);
  assign is_nl = (character == CH_NEWLINE);
  assign is_cr = (character == CH_RETURN);
  assign over  = (is_sp || is_nl) && (rw_b >= {4'b0, max_width});

  assign ci_ext     = {1'b0, ci_b};
  assign next_start = ci_ext + 17'd1;

  // Slot numbering for up to two breaks in a row
  assign ok0    = (bc_b < SLOT_CAP);
  assign bc_one = ok0 ? bc_b + 8'd1 : bc_b;
  assign ok1    = (bc_one < SLOT_CAP);
  assign bc_two = ok1 ? bc_one + 8'd1 : bc_one;

  // Break words
  always_comb begin
    brk.count = over ? (is_nl ? 2'd2 : 2'd1) : (is_nl ? 2'd1 : 2'd0);
    brk.res[0].pos  = over ? $signed(ws_b - 17'd1) : $signed(ci_ext);
    brk.res[0].slot = ok0 ? bc_one : SLOT_FULL;
    brk.res[0].ovf  = !ok0;
    brk.res[0].last = (brk.count == 2'd1);
    brk.res[1].pos  = $signed(ci_ext);
    brk.res[1].slot = ok1 ? bc_two : SLOT_FULL;
    brk.res[1].ovf  = !ok1;
    brk.res[1].last = 1'b1;
  end

  // Next state
  always_comb begin
    char_index_next    = (ci_b < INDEX_CAP) ? ci_b + 16'd1 : ci_b;
    running_width_next = rw_b;
    word_start_next    = ws_b;
    word_width_next    = ww_b;
    break_count_next   = bc_b;
    priority if (over) begin
      running_width_next = is_nl ? '0 : ww_b;
      word_start_next    = next_start;
      word_width_next    = '0;
      break_count_next   = is_nl ? bc_two : bc_one;
    end else if (is_nl) begin
      running_width_next = '0;
      word_start_next    = next_start;
      word_width_next    = '0;
      break_count_next   = bc_one;
    end else if (!is_cr) begin
      if (is_sp) begin
        word_start_next = next_start;
        word_width_next = '0;
      end else begin
        word_width_next = sat_add(ww_b, glyph_width);
      end
      running_width_next = sat_add(rw_b, glyph_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_index    <= '0;
      running_width <= '0;
      word_start    <= '0;
      word_width    <= '0;
      break_count   <= '0;
    end else if (accept) begin
      char_index    <= char_index_next;
      running_width <= running_width_next;
      word_start    <= word_start_next;
      word_width    <= word_width_next;
      break_count   <= break_count_next;
    end
  end

endmodule

// ===== rtl/gwwb_fifo.sv =====
// Four-word result queue taking up to two break words per cycle.
// Depends on gwwb_pkg.
module gwwb_fifo
  import gwwb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  brk_pair_t push,
  input  logic      push_en,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output brk_t      out_word
);

  brk_t       mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = push_en ? push.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_word  = mem[rd_ptr];
  // Space for the worst case of two words
  assign room      = (count <= 3'd2);

  // Storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= push.res[0];
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.res[1];
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule

// ===== rtl/greedy_word_wrap_breaker_unit.sv =====
// Greedy word-wrap breaker: text bytes in, line break words out.
// Usage:
//   Input stream s_*: one text byte per word. s_tdata = {glyph_width,
//   character}, s_tuser = new_text (clears the run before this byte).
//   Output stream m_*: one break per word. m_tdata holds break_position
//   (17-bit signed, -1 = before text start) and line_slot; m_tuser flags
//   a break that did not fit the line table; m_tlast marks the final
//   break caused by one input byte.
//   APB port: one register, max_width, at byte address 0 (reset 600).
// Timing:
//   A byte is taken every cycle while the result queue has room for two
//   breaks. Its breaks are registered into the queue and reach m_* behind any
//   earlier breaks. Throughput is one byte per cycle while the queue has room;
//   an over-limit newline yields two breaks and the four-word queue drains
//   one per cycle when m_tready is high, so a string of those lowers s_tready.
// Reset (synchronous, rst high) clears the run state and empties the
// queue; max_width returns to 600. When the receiver stalls, the queue
// fills and s_tready drops; no break is lost.
// Depends on gwwb_pkg, gwwb_core and gwwb_fifo.
module greedy_word_wrap_breaker_unit
  import gwwb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Text input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] character, [15:8] glyph_width
  input  logic        s_tuser,   // [0] new_text
  // Break output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [16:0] break_position, [24:17] line_slot, zero above
  output logic        m_tuser,   // [0] overflow
  output logic        m_tlast,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_width;
  logic        accept, room;
  brk_pair_t   brk;
  brk_t        head;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_WIDTH) ? {16'b0, max_width} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width <= MAX_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_WIDTH)) begin
      max_width <= pwdata[15:0];
    end
  end

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  gwwb_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .new_text    (s_tuser),
    .character   (s_tdata[7:0]),
    .glyph_width (s_tdata[15:8]),
    .max_width   (max_width),
    .brk         (brk)
  );

  gwwb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (brk),
    .push_en   (accept),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (head)
  );

  // Output word packing
  assign m_tdata = {7'b0, head.slot, head.pos};
  assign m_tuser = head.ovf;
  assign m_tlast = head.last;

endmodule

// ===== rtl/gwwb_checker.sv =====
// Port-level checks for the word-wrap breaker, bound to the top level.
// Depends on greedy_word_wrap_breaker_unit_defines.svh.
`include "greedy_word_wrap_breaker_unit_defines.svh"

module gwwb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Queue comes out of reset empty and ready
  `GWWB_ASSERT_ALWAYS(a_reset_empty, rst |=> (!m_tvalid && s_tready), "queue not empty after reset")
  // Stalled break word holds
  `GWWB_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled break changed")
  // An unstored break always reports the full slot number
  `GWWB_ASSERT(a_ovf_slot, (m_tvalid && m_tuser) |-> (m_tdata[24:17] == 8'hFF), "overflow break with bad slot")
  // Stored breaks count from one; pad bits stay zero
  `GWWB_ASSERT(a_slot_pad, m_tvalid |-> ((m_tdata[24:17] != 8'h00) && (m_tdata[31:25] == 7'h00)), "bad slot or padding")

endmodule

bind greedy_word_wrap_breaker_unit gwwb_checker u_gwwb_checker (.*);
